// ===== hdl/mlr_pkg.sv =====
// ---------------------------------------------------------------------------
// mlr_pkg: shared types and constants of the midpoint line rasterizer
// Item structs for both channels, the controller/datapath command and
// status bundles, and the coordinate and decision widths.
// ---------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

  // Coordinate width and the signed width of the decision terms
  localparam int COORD_BITS = 10;
  localparam int DEC_BITS   = COORD_BITS + 3;

  // Request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  // Input item
  typedef struct packed {
    logic   req_type;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } mlr_in_t;

  // Result item
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   pixel_valid;
    logic   last_pixel;
  } mlr_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch endpoints of a start item
    logic order_en;  // pick major axis and order endpoints
    logic setup_en;  // load line state and emit first pixel
    logic step_en;   // advance one pixel, or emit an invalid result
  } mlr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free; // output register can take a result this cycle
  } mlr_sts_t;

endpackage

`default_nettype wire

// ===== hdl/midpoint_line_rasterizer_unit.sv =====
// ---------------------------------------------------------------------------
// midpoint_line_rasterizer_unit: midpoint line rasterizer, all octants
// Start items load a line and give its first pixel; step items give the
// next pixel, with a last flag at the end point, or an invalid result with no line.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------
//   input   | in_valid_i / in_stall_o    | in_data_i  (mlr_in_t)
//   output  | out_valid_o / out_stall_i  | out_data_o (mlr_out_t)
//
// A step item is accepted, advanced and written to the output register in the
// same cycle, so steps stream at one pixel per clock while the output is not stalled.
// A start item goes through accept, endpoint ordering, then setup of the decision
// terms together with the first pixel; setup waits for room in the output register.
// Reset clears the sequencer, the line-active flag and the output valid.
// The output register holds under out_stall_i; input stalls during a start's
// ordering and setup cycles and while a held result is not being taken.
// ---------------------------------------------------------------------------
`default_nettype none

module midpoint_line_rasterizer_unit
  import mlr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire mlr_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output mlr_out_t     out_data_o
);

  mlr_cmd_t cmd;
  mlr_sts_t sts;

  mlr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_data_i.req_type),
    .in_stall_o    (in_stall_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  mlr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hdl/mlr_ctrl.sv =====
// ---------------------------------------------------------------------------
// mlr_ctrl: sequencer of the midpoint line rasterizer
// Accepts items, runs the ordering and setup states of a start, and issues the
// single-cycle step command when the output register has room.
// ---------------------------------------------------------------------------
`default_nettype none

module mlr_ctrl
  import mlr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_req_type_i,
  output logic          in_stall_o,
  input  wire mlr_sts_t sts_i,
  output mlr_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_SETUP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  // Take an item only in idle with room for its result
  assign in_stall_o = !((state_q == ST_IDLE) && sts_i.slot_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type_i == REQ_STEP) begin
            cmd_o.step_en = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = ST_ORDER;
          end
        end
      end
      ST_ORDER: begin
        cmd_o.order_en = 1'b1;
        state_d        = ST_SETUP;
      end
      ST_SETUP: begin
        if (sts_i.slot_free) begin
          cmd_o.setup_en = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // At most one datapath command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.order_en, cmd_o.setup_en, cmd_o.step_en}))
    else $error("mlr_ctrl: more than one datapath command");

  // Setup is only reached through the ordering cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP) |-> ($past(state_q) == ST_ORDER || $past(state_q) == ST_SETUP))
    else $error("mlr_ctrl: setup entered without ordering");

  // A captured start is ordered in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.order_en)
    else $error("mlr_ctrl: capture not followed by ordering");

endmodule

`default_nettype wire

// ===== hdl/mlr_datapath.sv =====
// ---------------------------------------------------------------------------
// mlr_datapath: line state, decision arithmetic and output register
// Orders endpoints, derives the decision variable and its increments, and
// advances one pixel per step command.
// ---------------------------------------------------------------------------
`default_nettype none

module mlr_datapath
  import mlr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mlr_in_t  in_data_i,
  input  wire mlr_cmd_t cmd_i,
  output mlr_sts_t      sts_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output mlr_out_t      out_data_o
);

  // Captured endpoints
  coord_t x0_q, y0_q, x1_q, y1_q;
  // Ordered endpoints (a: major axis, b: minor axis)
  coord_t a0_q, b0_q, a1_q;
  logic signed [COORD_BITS:0] dmin_q;
  // Line state
  coord_t major_q, minor_q, end_q;
  dec_t   decision_q, str_inc_q, diag_inc_q;
  logic   steep_q, minor_down_q, active_q;
  // Output register
  logic     out_valid_q;
  mlr_out_t out_q, out_d;

  // Ordering logic
  coord_t adx, ady, oa0, ob0, oa1, ob1;
  logic   ord_steep, swap;

  // Setup logic
  coord_t dmaj;
  dec_t   dmaj_ext, dmin2, su_decision, su_diag;
  logic   su_down, su_last;

  // Step logic
  logic   diag, st_last;
  coord_t major_nxt, minor_nxt;
  dec_t   dec_nxt;

  assign sts_o.slot_free = !out_valid_q || !out_stall_i;

  // Pick major axis and order endpoints along it
  always_comb begin
    adx       = (x1_q > x0_q) ? x1_q - x0_q : x0_q - x1_q;
    ady       = (y1_q > y0_q) ? y1_q - y0_q : y0_q - y1_q;
    ord_steep = !(adx > ady);
    oa0 = ord_steep ? y0_q : x0_q;
    ob0 = ord_steep ? x0_q : y0_q;
    oa1 = ord_steep ? y1_q : x1_q;
    ob1 = ord_steep ? x1_q : y1_q;
    swap = (oa1 < oa0) || ((oa1 == oa0) && (ob1 < ob0));
  end

  // Decision variable and increments from the ordered endpoints
  always_comb begin
    dmaj        = a1_q - a0_q;
    dmaj_ext    = dec_t'({1'b0, dmaj});
    dmin2       = dec_t'(dmin_q) <<< 1;
    su_down     = !(dmin_q > 0);
    su_decision = su_down ? dmin2 + dmaj_ext : dmin2 - dmaj_ext;
    su_diag     = su_down ? dmin2 + (dmaj_ext <<< 1) : dmin2 - (dmaj_ext <<< 1);
    su_last     = (a0_q == a1_q);
  end

  // One pixel step
  always_comb begin
    diag      = minor_down_q ? (decision_q <= 0) : (decision_q > 0);
    dec_nxt   = decision_q + (diag ? diag_inc_q : str_inc_q);
    minor_nxt = minor_q;
    if (diag) begin
      minor_nxt = minor_down_q ? minor_q - COORD_BITS'(1) : minor_q + COORD_BITS'(1);
    end
    major_nxt = major_q + COORD_BITS'(1);
    st_last   = (major_nxt == end_q);
  end

  // Result to load into the output register
  always_comb begin
    out_d = '0;
    if (cmd_i.setup_en) begin
      out_d.pixel_x     = steep_q ? b0_q : a0_q;
      out_d.pixel_y     = steep_q ? a0_q : b0_q;
      out_d.pixel_valid = 1'b1;
      out_d.last_pixel  = su_last;
    end else if (active_q) begin
      out_d.pixel_x     = steep_q ? minor_nxt : major_nxt;
      out_d.pixel_y     = steep_q ? major_nxt : minor_nxt;
      out_d.pixel_valid = 1'b1;
      out_d.last_pixel  = st_last;
    end
  end

  // Endpoint, ordering and line payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x0_q <= in_data_i.start_x;
      y0_q <= in_data_i.start_y;
      x1_q <= in_data_i.end_x;
      y1_q <= in_data_i.end_y;
    end
    if (cmd_i.order_en) begin
      steep_q <= ord_steep;
      a0_q    <= swap ? oa1 : oa0;
      b0_q    <= swap ? ob1 : ob0;
      a1_q    <= swap ? oa0 : oa1;
      dmin_q  <= swap ? $signed({1'b0, ob0}) - $signed({1'b0, ob1})
                      : $signed({1'b0, ob1}) - $signed({1'b0, ob0});
    end
    if (cmd_i.setup_en) begin
      major_q      <= a0_q;
      minor_q      <= b0_q;
      end_q        <= a1_q;
      decision_q   <= su_decision;
      str_inc_q    <= dmin2;
      diag_inc_q   <= su_diag;
      minor_down_q <= su_down;
    end else if (cmd_i.step_en && active_q) begin
      major_q    <= major_nxt;
      minor_q    <= minor_nxt;
      decision_q <= dec_nxt;
    end
    if (cmd_i.setup_en || cmd_i.step_en) begin
      out_q <= out_d;
    end
  end

  // Line activity and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.setup_en) begin
        active_q <= !su_last;
      end else if (cmd_i.step_en && active_q && st_last) begin
        active_q <= 1'b0;
      end
      if (cmd_i.setup_en || cmd_i.step_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A held last pixel means the line has ended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last_pixel) |-> !active_q)
    else $error("mlr_datapath: line still active after last pixel");

  // An invalid result is only produced with no line running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.pixel_valid) |-> !active_q)
    else $error("mlr_datapath: invalid result while line active");

  // A stalled result stays valid and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("mlr_datapath: stalled result changed");

endmodule

`default_nettype wire
